/* rtl/crlfp_pkg.sv */
// ----------------------------------------------------------------------------
// CRLF line parser package
// Shared types and constants for the response line parser: byte codes,
// prefix strings, line kinds and the records passed between the parts.
// ----------------------------------------------------------------------------
package crlfp_pkg;

    // Width of a line length or a character position.
    localparam int LEN_W = 6;

    // Control byte codes.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Prefix and keyword strings, first character in the top byte.
    localparam int          CENTRAL_LEN = 8;
    localparam int          PERIPH_LEN  = 11;
    localparam int          ERROR_LEN   = 5;
    localparam logic [63:0] CENTRAL_STR = "Central:";
    localparam logic [87:0] PERIPH_STR  = "Peripheral:";
    localparam logic [39:0] ERROR_STR   = "ERROR";

    // Classification of a completed line.
    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_CENTRAL = 2'd1,
        KIND_PERIPH  = 2'd2,
        KIND_ERROR   = 2'd3
    } t_line_kind;

    // One completed line waiting to be emitted.
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        t_line_kind       kind;
    } t_line_desc;

    // Write request into the line store.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } t_store_wr;

    // Line queue status.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    // Emitter states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_HOLD
    } t_back_state;

endpackage

/* rtl/crlf_response_line_parser.sv */
// After its LF is accepted, a line is registered into the line queue; the idle emitter then
// reads the store and loads the first character item, or loads an error item directly.
// Throughput in: one byte per cycle; input stalls only while two lines wait in the queue.
// Output: each character item is read from the store, loaded and handed over before the next
// is read; the emitter returns to idle ahead of each next line and loads an error item from idle.
// Reset clears the fill index, the line queue and the emitter; the store is not cleared.
// ----------------------------------------------------------------------------
// CRLF response line parser
// Assembles CR LF terminated lines from received bytes and emits each
// qualifying line as classified character items, or one error item.
// ----------------------------------------------------------------------------
module crlf_response_line_parser
    import crlfp_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,  // [0] error_check
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [7:0] character, [13:8] position, [15:14] zero
    output logic [2:0]  o_m_tuser,  // [1:0] line_kind, [2] in_address
    output logic        o_m_tlast   // last
);

    logic             w_push;
    logic             w_pop;
    t_line_desc       w_in_desc;
    t_line_desc       w_head;
    t_queue_stat      w_stat;
    t_store_wr        w_wr;
    t_line_kind       w_kind;
    logic [7:0]       w_char;
    logic [LEN_W-1:0] w_pos;
    logic             w_in_addr;

    // Byte intake and line classification.
    crlfp_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_check (i_s_tuser[0]),
        .i_full  (w_stat.full),
        .o_push  (w_push),
        .o_desc  (w_in_desc),
        .o_wr    (w_wr)
    );

    // Completed line queue.
    crlfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_in_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Line store and result emitter.
    crlfp_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_desc    (w_head),
        .i_stat    (w_stat),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (w_kind),
        .o_char    (w_char),
        .o_pos     (w_pos),
        .o_in_addr (w_in_addr),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_pos, w_char};
    assign o_m_tuser = {w_in_addr, w_kind};

endmodule

/* rtl/crlfp_front.sv */
// ----------------------------------------------------------------------------
// CRLF line parser front end
// Accepts received bytes, writes them into the current store bank, tracks
// prefix matches as bytes arrive and queues each qualifying line on LF.
// ----------------------------------------------------------------------------
module crlfp_front
    import crlfp_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_check,
    input  logic       i_full,
    output logic       o_push,
    output t_line_desc o_desc,
    output t_store_wr  o_wr
);

    localparam int IW = $clog2(LINE_LEN);

    logic [IW-1:0]         r_fill, n_fill;
    logic                  r_bank;
    logic                  r_last_cr;
    logic [CENTRAL_LEN-1:0] r_c_ok, n_c_ok;
    logic [PERIPH_LEN-1:0]  r_p_ok, n_p_ok;
    logic [ERROR_LEN-1:0]   r_e_ok, n_e_ok;

    logic             w_accept;
    logic             w_is_lf;
    logic [LEN_W-1:0] w_fill6;
    logic [LEN_W-1:0] w_len;
    logic             w_qualify;
    t_line_kind       w_kind;

    assign o_ready   = !i_full;
    assign w_accept  = i_valid && !i_full;
    assign w_is_lf   = (i_byte == CHAR_LF);
    assign w_fill6   = LEN_W'(r_fill);
    assign w_len     = w_fill6 - LEN_W'(1);
    assign w_qualify = (w_fill6 > LEN_W'(2)) && r_last_cr;

    // Fill index advances and wraps at the size of one store bank.
    always_comb begin
        if (r_fill == IW'(LINE_LEN - 1)) begin
            n_fill = '0;
        end else begin
            n_fill = r_fill + IW'(1);
        end
    end

    // Per-position match bits follow the byte written at each position.
    always_comb begin
        for (int k = 0; k < CENTRAL_LEN; k++) begin
            n_c_ok[k] = (w_fill6 == LEN_W'(k))
                      ? (i_byte == CENTRAL_STR[8*(CENTRAL_LEN-1-k) +: 8]) : r_c_ok[k];
        end
        for (int k = 0; k < PERIPH_LEN; k++) begin
            n_p_ok[k] = (w_fill6 == LEN_W'(k))
                      ? (i_byte == PERIPH_STR[8*(PERIPH_LEN-1-k) +: 8]) : r_p_ok[k];
        end
        for (int k = 0; k < ERROR_LEN; k++) begin
            n_e_ok[k] = (w_fill6 == LEN_W'(k))
                      ? (i_byte == ERROR_STR[8*(ERROR_LEN-1-k) +: 8]) : r_e_ok[k];
        end
    end

    // Line classification at LF; Central is tested before Peripheral.
    always_comb begin
        if (i_check && (w_len == LEN_W'(ERROR_LEN)) && (&r_e_ok)) begin
            w_kind = KIND_ERROR;
        end else if ((w_len >= LEN_W'(CENTRAL_LEN)) && (&r_c_ok)) begin
            w_kind = KIND_CENTRAL;
        end else if ((w_len >= LEN_W'(PERIPH_LEN)) && (&r_p_ok)) begin
            w_kind = KIND_PERIPH;
        end else begin
            w_kind = KIND_PLAIN;
        end
    end

    // Store write and queue push.
    assign o_wr.en     = w_accept && !w_is_lf;
    assign o_wr.bank   = r_bank;
    assign o_wr.idx    = w_fill6;
    assign o_wr.data   = i_byte;
    assign o_push      = w_accept && w_is_lf && w_qualify;
    assign o_desc.bank = r_bank;
    assign o_desc.len  = w_len;
    assign o_desc.kind = w_kind;

    // Front state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_bank    <= 1'b0;
            r_last_cr <= 1'b0;
            r_c_ok    <= '0;
            r_p_ok    <= '0;
            r_e_ok    <= '0;
        end else if (w_accept) begin
            if (w_is_lf) begin
                r_fill    <= '0;
                r_last_cr <= 1'b0;
                if (w_qualify) begin
                    r_bank <= ~r_bank;
                end
            end else begin
                r_fill    <= n_fill;
                r_last_cr <= (i_byte == CHAR_CR);
                r_c_ok    <= n_c_ok;
                r_p_ok    <= n_p_ok;
                r_e_ok    <= n_e_ok;
            end
        end
    end

endmodule

/* rtl/crlfp_queue.sv */
// ----------------------------------------------------------------------------
// CRLF line parser line queue
// Two-entry queue of completed line records between the front end and the
// emitter; entry order matches the alternating store banks.
// ----------------------------------------------------------------------------
module crlfp_queue
    import crlfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_line_desc  i_desc,
    input  logic        i_pop,
    output t_line_desc  o_head,
    output t_queue_stat o_stat
);

    t_line_desc r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.full  = (r_count == 2'd2);

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/crlfp_back.sv */
// ----------------------------------------------------------------------------
// CRLF line parser emitter
// Holds the two-bank line store and walks each queued line, giving one
// result item per character, or a single item for an error line.
// ----------------------------------------------------------------------------
module crlfp_back
    import crlfp_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_wr        i_wr,
    input  t_line_desc       i_desc,
    input  t_queue_stat      i_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_line_kind       o_kind,
    output logic [7:0]       o_char,
    output logic [LEN_W-1:0] o_pos,
    output logic             o_in_addr,
    output logic             o_last
);

    localparam int AW    = $clog2(2 * LINE_LEN);
    localparam int DEPTH = 2 * LINE_LEN;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    t_back_state      r_state, n_state;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_valid, n_valid;
    t_line_kind       r_kind, n_kind;
    logic [7:0]       r_char, n_char;
    logic [LEN_W-1:0] r_pos_out, n_pos_out;
    logic             r_in_addr, n_in_addr;
    logic             r_last, n_last;

    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;
    logic             w_addr_flag;

    // Bank one sits above bank zero in the store.
    assign w_wr_addr = AW'(i_wr.idx) + (i_wr.bank ? AW'(LINE_LEN) : AW'(0));
    assign w_rd_addr = AW'(r_pos) + (i_desc.bank ? AW'(LINE_LEN) : AW'(0));

    // Line store: one write port from the front end, one registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_wr_addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Characters after the prefix of an address line are marked.
    assign w_addr_flag = ((i_desc.kind == KIND_CENTRAL) && (r_pos >= LEN_W'(CENTRAL_LEN)))
                      || ((i_desc.kind == KIND_PERIPH) && (r_pos >= LEN_W'(PERIPH_LEN)));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_stat.empty) begin
                    n_state = (i_desc.kind == KIND_ERROR) ? BK_HOLD : BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                n_state = BK_HOLD;
            end
            BK_HOLD: begin
                if (i_ready) begin
                    n_state = r_last ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Output register loading and queue pop.
    always_comb begin
        n_pos     = r_pos;
        n_valid   = r_valid;
        n_kind    = r_kind;
        n_char    = r_char;
        n_pos_out = r_pos_out;
        n_in_addr = r_in_addr;
        n_last    = r_last;
        o_pop     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_stat.empty) begin
                    n_pos = '0;
                    if (i_desc.kind == KIND_ERROR) begin
                        n_valid   = 1'b1;
                        n_kind    = KIND_ERROR;
                        n_char    = 8'd0;
                        n_pos_out = '0;
                        n_in_addr = 1'b0;
                        n_last    = 1'b1;
                    end
                end
            end
            BK_READ: begin
            end
            BK_LOAD: begin
                n_valid   = 1'b1;
                n_kind    = i_desc.kind;
                n_char    = r_rd_data;
                n_pos_out = r_pos;
                n_in_addr = w_addr_flag;
                n_last    = ((r_pos + LEN_W'(1)) == i_desc.len);
            end
            BK_HOLD: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        o_pop = 1'b1;
                    end else begin
                        n_pos = r_pos + LEN_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Emitter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_pos   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_char    <= n_char;
        r_pos_out <= n_pos_out;
        r_in_addr <= n_in_addr;
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_char    = r_char;
    assign o_pos     = r_pos_out;
    assign o_in_addr = r_in_addr;
    assign o_last    = r_last;

endmodule

/* test/crlf_response_line_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRLF response line parser testbench
// Streams received bytes into the parser and predicts each line's character
// items or error item in a behavioral model kept in step with the accepted
// bytes. Result items are checked in order against the prediction. Sender
// gaps, receiver stalls and one long output hold-off vary the timing.
// ----------------------------------------------------------------------------
module crlf_response_line_parser_test;
    import crlfp_pkg::*;

    localparam int LINE_LEN       = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 32;

    // Line shapes for the random stimulus.
    localparam int SHAPE_ANY      = -1;
    localparam int SHAPE_PLAIN    = 0;
    localparam int SHAPE_CENTRAL  = 1;
    localparam int SHAPE_PERIPH   = 2;
    localparam int SHAPE_NEAR     = 3;
    localparam int SHAPE_ERROR    = 4;
    localparam int SHAPE_OVERLONG = 5;
    localparam int SHAPE_NO_CR    = 6;
    localparam int SHAPE_NOISE    = 7;
    localparam int SHAPE_ZEROS    = 8;

    // One expected character item (or error item) on the output stream.
    typedef struct {
        t_line_kind kind;
        logic [7:0] ch;
        logic [5:0] pos;
        logic       in_addr;
        logic       last;
    } t_char_item;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] rx_byte
    logic [0:0]  i_s_tuser  = '0;   // [0] error_check
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [7:0] character, [13:8] position, [15:14] zero
    logic [2:0]  o_m_tuser;         // [1:0] line_kind, [2] in_address
    logic        o_m_tlast;

    // Line assembly state of the predictor.
    logic [7:0] line_buf [LINE_LEN];
    int         fill_pos = 0;
    t_char_item pending_chars [$];

    int fail_count     = 0;
    int bytes_sent     = 0;
    int chars_checked  = 0;
    int error_items    = 0;
    int address_chars  = 0;
    int input_stalls   = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    crlf_response_line_parser #(
        .LINE_LEN(LINE_LEN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Character i of a string constant that holds its first character on top.
    function automatic logic [7:0] str_char(input logic [87:0] s, input int n, input int i);
        return s[8*(n-1-i) +: 8];
    endfunction

    function automatic bit line_starts_with(input int len, input logic [87:0] s, input int n);
        int i;
        if (len < n) return 1'b0;
        for (i = 0; i < n; i++) begin
            if (line_buf[i] !== str_char(s, n, i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Track one accepted byte and queue the items that its LF releases.
    function automatic void parse_rx_byte(input logic [7:0] b, input logic chk);
        int         held;
        int         len;
        int         cut;
        int         i;
        t_line_kind kind;
        t_char_item item;
        if (b != CHAR_LF) begin
            line_buf[fill_pos] = b;
            fill_pos = (fill_pos + 1) % LINE_LEN;
            return;
        end
        held = fill_pos;
        fill_pos = 0;
        if (held <= 2 || line_buf[held-1] != CHAR_CR) return;
        len = held - 1;

        // An exact ERROR line collapses into a single error item.
        if (chk && len == ERROR_LEN && line_starts_with(len, 88'(ERROR_STR), ERROR_LEN)) begin
            item.kind    = KIND_ERROR;
            item.ch      = 8'h00;
            item.pos     = 6'd0;
            item.in_addr = 1'b0;
            item.last    = 1'b1;
            pending_chars.push_back(item);
            return;
        end

        if (line_starts_with(len, 88'(CENTRAL_STR), CENTRAL_LEN)) begin
            kind = KIND_CENTRAL;
            cut  = CENTRAL_LEN;
        end else if (line_starts_with(len, PERIPH_STR, PERIPH_LEN)) begin
            kind = KIND_PERIPH;
            cut  = PERIPH_LEN;
        end else begin
            kind = KIND_PLAIN;
            cut  = len;
        end
        for (i = 0; i < len; i++) begin
            item.kind    = kind;
            item.ch      = line_buf[i];
            item.pos     = 6'(i);
            item.in_addr = (kind != KIND_PLAIN) && (i >= cut);
            item.last    = (i == len - 1);
            pending_chars.push_back(item);
        end
    endfunction

    // Offer one byte, with random gaps ahead of it, and wait for acceptance.
    // Returns at the next falling edge with valid still high: the caller must
    // send again or lower valid before letting time pass.
    task automatic send_item(input logic [7:0] b, input logic chk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= chk;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        parse_rx_byte(b, chk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line_text(input string s, input logic chk);
        int i;
        for (i = 0; i < s.len(); i++) send_item(s[i], chk);
        send_item(CHAR_CR, chk);
        send_item(CHAR_LF, chk);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
        return b;
    endfunction

    function automatic void append_str(ref logic [7:0] q[$], input logic [87:0] s,
                                       input int n);
        int i;
        for (i = 0; i < n; i++) q.push_back(str_char(s, n, i));
    endfunction

    // Build one line of the given shape (or a random one) and send it.
    task automatic send_random_line(input int shape);
        logic [7:0]  text_q [$];
        logic [87:0] pfx;
        int          plen;
        int          n;
        int          i;
        int          sel;
        bit          add_cr;
        bit          add_lf;
        logic        lf_chk;
        add_cr = 1'b1;
        add_lf = 1'b1;
        lf_chk = 1'($urandom_range(0, 1));
        if (shape == SHAPE_ANY) begin
            sel = $urandom_range(0, 15);
            case (sel)
                4, 5:    shape = SHAPE_CENTRAL;
                6, 7:    shape = SHAPE_PERIPH;
                8:       shape = SHAPE_NEAR;
                9, 10:   shape = SHAPE_ERROR;
                11:      shape = SHAPE_OVERLONG;
                12:      shape = SHAPE_NO_CR;
                13:      shape = SHAPE_NOISE;
                14:      shape = SHAPE_ZEROS;
                default: shape = SHAPE_PLAIN;
            endcase
        end

        case (shape)
            SHAPE_CENTRAL: begin
                append_str(text_q, 88'(CENTRAL_STR), CENTRAL_LEN);
                repeat ($urandom_range(0, 22)) text_q.push_back(text_byte());
            end
            SHAPE_PERIPH: begin
                append_str(text_q, PERIPH_STR, PERIPH_LEN);
                repeat ($urandom_range(0, 19)) text_q.push_back(text_byte());
            end
            SHAPE_NEAR: begin
                // Truncated or slightly damaged prefix, so the line stays plain
                // unless the full prefix is kept and left undamaged.
                if ($urandom_range(0, 1)) begin
                    pfx  = 88'(CENTRAL_STR);
                    plen = CENTRAL_LEN;
                end else begin
                    pfx  = PERIPH_STR;
                    plen = PERIPH_LEN;
                end
                n = $urandom_range(1, plen);
                for (i = 0; i < n; i++) text_q.push_back(str_char(pfx, plen, i));
                if ($urandom_range(0, 1)) begin
                    i = $urandom_range(0, n - 1);
                    text_q[i] = text_q[i] ^ (8'h01 << $urandom_range(0, 7));
                end
                repeat ($urandom_range(0, 8)) text_q.push_back(text_byte());
            end
            SHAPE_ERROR: begin
                lf_chk = ($urandom_range(0, 3) != 0);
                append_str(text_q, 88'(ERROR_STR), ERROR_LEN);
                case ($urandom_range(0, 3))
                    1: text_q.push_back(text_byte());
                    2: void'(text_q.pop_back());
                    3: begin
                        i = $urandom_range(0, ERROR_LEN - 1);
                        text_q[i] = text_q[i] ^ (8'h01 << $urandom_range(0, 7));
                    end
                    default: ;
                endcase
            end
            SHAPE_OVERLONG: begin
                // Wraps the fill index, so only the tail after the wrap counts.
                repeat ($urandom_range(31, 70)) text_q.push_back(text_byte());
            end
            SHAPE_NO_CR: begin
                add_cr = 1'b0;
                repeat ($urandom_range(0, 20)) text_q.push_back(text_byte());
            end
            SHAPE_NOISE: begin
                add_cr = 1'b0;
                add_lf = 1'b0;
                repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
            end
            SHAPE_ZEROS: begin
                // Zero bytes and stray CRs inside the line body.
                n = $urandom_range(2, 28);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 2))
                        0:       text_q.push_back(8'h00);
                        1:       text_q.push_back(CHAR_CR);
                        default: text_q.push_back(text_byte());
                    endcase
                end
            end
            default: begin
                repeat ($urandom_range(0, 29)) text_q.push_back(text_byte());
            end
        endcase

        if (add_cr) text_q.push_back(CHAR_CR);
        for (i = 0; i < text_q.size(); i++) send_item(text_q[i], 1'($urandom_range(0, 1)));
        if (add_lf) send_item(CHAR_LF, lf_chk);
    endtask

    // Extremes of the byte field, both ERROR treatments and the dropped lines.
    task automatic test_directed_lines();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_line_text("ERROR", 1'b1);
        send_line_text("ERROR", 1'b0);
        // Lines with too few bytes held are dropped.
        send_line_text("", 1'b1);
        send_line_text("A", 1'b1);
        // Smallest and largest byte values as line content.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b1);
        // A line without CR before its LF is dropped.
        send_item("Z", 1'b1);
        send_item(8'h00, 1'b0);
        send_item(CHAR_LF, 1'b0);
    endtask

    task automatic test_random_lines(input int n_items, input int send_pct,
                                     input int recv_pct);
        int target;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = bytes_sent + n_items;
        while (bytes_sent < target) send_random_line(SHAPE_ANY);
    endtask

    // Hold the output off for a long stretch while lines keep arriving, so the
    // line queue fills and the input side has to stall. The address lines go
    // first since they always qualify; the plain lines then meet a full queue.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        send_random_line(SHAPE_CENTRAL);
        send_random_line(SHAPE_PERIPH);
        repeat (3) send_random_line(SHAPE_PLAIN);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output ready: random stalls, plus a counted hold-off on request.
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result item with the oldest expected item.
    always @(posedge i_clk) begin
        t_char_item want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_chars.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item kind=%0d ch=%h pos=%0d addr=%b last=%b",
                         $time, o_m_tuser[1:0], o_m_tdata[7:0], o_m_tdata[13:8],
                         o_m_tuser[2], o_m_tlast);
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (want.kind == KIND_ERROR) error_items++;
                if (want.in_addr) address_chars++;
                if (o_m_tuser[1:0] !== want.kind || o_m_tdata[7:0] !== want.ch ||
                    o_m_tdata[13:8] !== want.pos || o_m_tuser[2] !== want.in_addr ||
                    o_m_tlast !== want.last || o_m_tdata[15:14] !== 2'b00) begin
                    fail_count++;
                    $display("%0t: mismatch expected kind=%0d ch=%h pos=%0d addr=%b last=%b",
                             $time, want.kind, want.ch, want.pos, want.in_addr, want.last);
                    $display("%0t:          actual   kind=%0d ch=%h pos=%0d addr=%b last=%b pad=%b",
                             $time, o_m_tuser[1:0], o_m_tdata[7:0], o_m_tdata[13:8],
                             o_m_tuser[2], o_m_tlast, o_m_tdata[15:14]);
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (i_rst_n && i_s_tvalid && !o_s_tready) input_stalls++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d items still expected",
                     $time, idle_cycles, pending_chars.size());
            $display("crlf_response_line_parser verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_lines();
        test_random_lines(PHASE_ITEMS, 0, 0);
        test_random_lines(PHASE_ITEMS, 65, 0);
        test_random_lines(PHASE_ITEMS, 0, 65);
        test_random_lines(PHASE_ITEMS, 8, 8);
        test_output_backpressure();
        wait_drained();

        $display("Covered %0d bytes and %0d result items (%0d error, %0d address chars);",
                 bytes_sent, chars_checked, error_items, address_chars);
        $display("the input side was held back for %0d cycles.", input_stalls);
        if (fail_count == 0) begin
            $display("crlf_response_line_parser verification clean");
        end else begin
            $display("crlf_response_line_parser verification failed");
        end
        $finish;
    end

endmodule
